FILE: rtl/pbm_pkg.sv
package pbm_pkg;

    localparam int DEF_WEIGHT_BITS = 8;
    localparam int DEF_MAX_SRC_DIM = 4096;
    localparam int DEF_MAX_DST_DIM = 1024;

    localparam int FRAC_BITS      = 16;
    localparam int W_THRESHOLD    = 268;
    localparam int QUOT_INT_BITS  = 8;
    localparam int QUOT_BITS      = QUOT_INT_BITS + 12 + FRAC_BITS;
    localparam int SRC_W          = QUOT_BITS + 2;
    localparam int IX_W           = SRC_W - FRAC_BITS;
    localparam int DIM_W          = 13;

    typedef enum logic [2:0] {
        REG_XROW_PAIR      = 3'd0,
        REG_XCONST_YFIRST  = 3'd1,
        REG_YROW_PAIR      = 3'd2,
        REG_WROW_PAIR      = 3'd3,
        REG_WCONST         = 3'd4,
        REG_SOURCE_SIZE    = 3'd5,
        REG_SOURCE_LAYOUT  = 3'd6,
        REG_DEST_GRID      = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0]      h00;
        logic [31:0]      h01;
        logic [31:0]      h02;
        logic [31:0]      h10;
        logic [31:0]      h11;
        logic [31:0]      h12;
        logic [31:0]      h20;
        logic [31:0]      h21;
        logic [31:0]      h22;
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
        logic [DIM_W-1:0] stride;
        logic [1:0]       bpp;
        logic [1:0]       scale;
        logic [1:0]       xoff;
        logic [1:0]       yoff;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             w_ok;
        logic [SRC_W-1:0] sx;
        logic [SRC_W-1:0] sy;
    } proj_t;

endpackage

FILE: rtl/pbm_if.sv
interface pbm_pix_if;
    logic       valid;
    logic       ready;
    logic [9:0] dst_col;
    logic [9:0] dst_row;

    modport source (output valid, dst_col, dst_row, input ready);
    modport sink (input valid, dst_col, dst_row, output ready);
endinterface

interface pbm_map_if;
    logic        valid;
    logic        ready;
    logic [24:0] base_offset;
    logic [1:0]  step_right;
    logic [13:0] step_down;
    logic [8:0]  weight_top_left;
    logic [8:0]  weight_top_right;
    logic [8:0]  weight_bottom_left;
    logic [8:0]  weight_bottom_right;

    modport source (output valid, base_offset, step_right, step_down, weight_top_left,
                    weight_top_right, weight_bottom_left, weight_bottom_right, input ready);
    modport sink (input valid, base_offset, step_right, step_down, weight_top_left,
                  weight_top_right, weight_bottom_left, weight_bottom_right, output ready);
endinterface

FILE: rtl/perspective_bilinear_map_gen.sv
// Generates one bilinear sample-map entry per destination pixel through a homography and
// accepts a new pixel in every cycle while map_out is not stalled. Each transfer on pix_in
// produces exactly one transfer on map_out, through the grid scaling and the homography
// products and sums, operand preparation, the restoring divider (one quotient bit per
// stage, x and y lanes side by side), the floor correction and the weights and byte
// offset. A stall on map_out holds the whole pipeline in place. The user must write
// registers only while the pipeline is empty; the block itself does not enforce this.
module perspective_bilinear_map_gen
    import pbm_pkg::*;
#(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int MAX_SRC_DIM = DEF_MAX_SRC_DIM,
    parameter int MAX_DST_DIM = DEF_MAX_DST_DIM
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    pbm_pix_if.sink     pix_in,
    pbm_map_if.source   map_out
);

    localparam int VAL_W = $clog2(3 * MAX_DST_DIM + 1) + 34;

    logic [63:0] xrow_reg, xconst_yfirst_reg, yrow_reg, wrow_reg;
    logic [31:0] wconst_reg;
    logic [28:0] source_size_reg;
    logic [17:0] source_layout_reg, dest_grid_reg;

    cfg_t  cfg;
    proj_t prj;
    logic  en;
    logic  front_valid;
    logic signed [VAL_W-1:0] xv, yv, wv;
    logic [14:0] chk_stride_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xrow_reg          <= '0;
            xconst_yfirst_reg <= '0;
            yrow_reg          <= '0;
            wrow_reg          <= '0;
            wconst_reg        <= '0;
            source_size_reg   <= '0;
            source_layout_reg <= '0;
            dest_grid_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_XROW_PAIR:     xrow_reg          <= cfg_data;
                REG_XCONST_YFIRST: xconst_yfirst_reg <= cfg_data;
                REG_YROW_PAIR:     yrow_reg          <= cfg_data;
                REG_WROW_PAIR:     wrow_reg          <= cfg_data;
                REG_WCONST:        wconst_reg        <= cfg_data[31:0];
                REG_SOURCE_SIZE:   source_size_reg   <= cfg_data[28:0];
                REG_SOURCE_LAYOUT: source_layout_reg <= cfg_data[17:0];
                REG_DEST_GRID:     dest_grid_reg     <= cfg_data[17:0];
            endcase
        end
    end

    assign cfg = '{
        h00:    xrow_reg[31:0],
        h01:    xrow_reg[63:32],
        h02:    xconst_yfirst_reg[31:0],
        h10:    xconst_yfirst_reg[63:32],
        h11:    yrow_reg[31:0],
        h12:    yrow_reg[63:32],
        h20:    wrow_reg[31:0],
        h21:    wrow_reg[63:32],
        h22:    wconst_reg,
        src_w:  source_size_reg[12:0],
        src_h:  source_size_reg[28:16],
        stride: source_layout_reg[12:0],
        bpp:    source_layout_reg[17:16],
        scale:  dest_grid_reg[1:0],
        xoff:   dest_grid_reg[9:8],
        yoff:   dest_grid_reg[17:16]
    };

    assign en = !map_out.valid || map_out.ready;
    assign pix_in.ready = en;

    pbm_front #(
        .MAX_DST_DIM(MAX_DST_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_in.valid),
        .dst_col   (pix_in.dst_col),
        .dst_row   (pix_in.dst_row),
        .cfg       (cfg),
        .out_valid (front_valid),
        .xv        (xv),
        .yv        (yv),
        .wv        (wv)
    );

    pbm_div #(
        .MAX_DST_DIM(MAX_DST_DIM)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (front_valid),
        .xv       (xv),
        .yv       (yv),
        .wv       (wv),
        .res      (prj)
    );

    pbm_back #(
        .WEIGHT_BITS(WEIGHT_BITS),
        .MAX_SRC_DIM(MAX_SRC_DIM)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .en                  (en),
        .prj                 (prj),
        .cfg                 (cfg),
        .out_valid           (map_out.valid),
        .base_offset         (map_out.base_offset),
        .step_right          (map_out.step_right),
        .step_down           (map_out.step_down),
        .weight_top_left     (map_out.weight_top_left),
        .weight_top_right    (map_out.weight_top_right),
        .weight_bottom_left  (map_out.weight_bottom_left),
        .weight_bottom_right (map_out.weight_bottom_right)
    );

    assign chk_stride_bytes = 15'(cfg.stride) * 15'(cfg.bpp);

    // Both left and right taps inside the source means the right step is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        map_out.valid && (map_out.weight_top_left != 9'd0)
        && (map_out.weight_top_right != 9'd0)
        |-> map_out.step_right == cfg.bpp)
        else $error("Right step missing although both upper taps carry weight.");

    assert property (@(posedge clk) disable iff (!rst_n)
        map_out.valid && (map_out.weight_top_left != 9'd0)
        && (map_out.weight_bottom_left != 9'd0)
        |-> map_out.step_down == chk_stride_bytes[13:0])
        else $error("Down step missing although both left taps carry weight.");

    // Rounding each weight half up can overshoot the total by at most two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (WEIGHT_BITS <= 8) && map_out.valid
        |-> (11'(map_out.weight_top_left) + 11'(map_out.weight_top_right)
             + 11'(map_out.weight_bottom_left) + 11'(map_out.weight_bottom_right))
            <= (11'(1) << WEIGHT_BITS) + 11'd2)
        else $error("Bilinear weights sum beyond full scale.");

endmodule

FILE: rtl/pbm_front.sv
module pbm_front
    import pbm_pkg::*;
#(
    parameter int MAX_DST_DIM = DEF_MAX_DST_DIM
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [9:0] dst_col,
    input  logic [9:0] dst_row,
    input  cfg_t cfg,
    output logic out_valid,
    output logic signed [$clog2(3 * MAX_DST_DIM + 1) + 33:0] xv,
    output logic signed [$clog2(3 * MAX_DST_DIM + 1) + 33:0] yv,
    output logic signed [$clog2(3 * MAX_DST_DIM + 1) + 33:0] wv
);

    localparam int DX_W   = $clog2(3 * MAX_DST_DIM + 1);
    localparam int PROD_W = DX_W + 33;
    localparam int VAL_W  = DX_W + 34;
    localparam logic [DIM_W-1:0] DST_MAX = DIM_W'(MAX_DST_DIM - 1);

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [DX_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic [DIM_W-1:0]  col_c, row_c;
    logic [DIM_W+1:0]  dx_full, dy_full;
    logic signed [PROD_W-1:0] prod_reg [6];
    logic signed [PROD_W-1:0] prod_next [6];
    logic signed [VAL_W-1:0]  xv_reg, yv_reg, wv_reg, xv_next, yv_next, wv_next;

    always_comb
    begin
        col_c = (DIM_W'(dst_col) > DST_MAX) ? DST_MAX : DIM_W'(dst_col);
        row_c = (DIM_W'(dst_row) > DST_MAX) ? DST_MAX : DIM_W'(dst_row);
        dx_full = (DIM_W+2)'(col_c) * (DIM_W+2)'(cfg.scale) + (DIM_W+2)'(cfg.xoff);
        dy_full = (DIM_W+2)'(row_c) * (DIM_W+2)'(cfg.scale) + (DIM_W+2)'(cfg.yoff);
        dx_next = DX_W'(dx_full);
        dy_next = DX_W'(dy_full);
    end

    always_comb
    begin
        prod_next[0] = $signed(cfg.h00) * $signed({1'b0, dx_reg});
        prod_next[1] = $signed(cfg.h01) * $signed({1'b0, dy_reg});
        prod_next[2] = $signed(cfg.h10) * $signed({1'b0, dx_reg});
        prod_next[3] = $signed(cfg.h11) * $signed({1'b0, dy_reg});
        prod_next[4] = $signed(cfg.h20) * $signed({1'b0, dx_reg});
        prod_next[5] = $signed(cfg.h21) * $signed({1'b0, dy_reg});
    end

    always_comb
    begin
        xv_next = VAL_W'(prod_reg[0]) + VAL_W'(prod_reg[1]) + VAL_W'($signed(cfg.h02));
        yv_next = VAL_W'(prod_reg[2]) + VAL_W'(prod_reg[3]) + VAL_W'($signed(cfg.h12));
        wv_next = VAL_W'(prod_reg[4]) + VAL_W'(prod_reg[5]) + VAL_W'($signed(cfg.h22));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            for (int i = 0; i < 6; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            xv_reg <= xv_next;
            yv_reg <= yv_next;
            wv_reg <= wv_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign xv = xv_reg;
    assign yv = yv_reg;
    assign wv = wv_reg;

endmodule

FILE: rtl/pbm_div.sv
module pbm_div
    import pbm_pkg::*;
#(
    parameter int MAX_DST_DIM = DEF_MAX_DST_DIM
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  logic signed [$clog2(3 * MAX_DST_DIM + 1) + 33:0] xv,
    input  logic signed [$clog2(3 * MAX_DST_DIM + 1) + 33:0] yv,
    input  logic signed [$clog2(3 * MAX_DST_DIM + 1) + 33:0] wv,
    output proj_t res
);

    localparam int DX_W  = $clog2(3 * MAX_DST_DIM + 1);
    localparam int VAL_W = DX_W + 34;
    localparam int MAG_W = VAL_W;
    localparam int REM_W = MAG_W + QUOT_INT_BITS;
    localparam int NS    = QUOT_BITS;
    localparam logic signed [VAL_W-1:0] W_POS = VAL_W'(W_THRESHOLD);
    localparam logic signed [VAL_W-1:0] W_NEG = -W_POS;

    // Operand magnitudes and signs.
    logic             a_valid_reg, a_negx_reg, a_negy_reg, a_wok_reg;
    logic [MAG_W-1:0] a_nx_reg, a_ny_reg, a_d_reg;

    // One quotient bit per stage, both lanes sharing the divisor.
    logic                 v_reg     [NS+1];
    logic                 wok_reg   [NS+1];
    logic                 negx_reg  [NS+1];
    logic                 negy_reg  [NS+1];
    logic                 satx_reg  [NS+1];
    logic                 saty_reg  [NS+1];
    logic [MAG_W-1:0]     d_reg     [NS+1];
    logic [REM_W-1:0]     rx_reg    [NS+1];
    logic [REM_W-1:0]     ry_reg    [NS+1];
    logic [QUOT_BITS-1:0] qx_reg    [NS+1];
    logic [QUOT_BITS-1:0] qy_reg    [NS+1];

    logic                 o_valid_reg, o_wok_reg;
    logic [SRC_W-1:0]     o_sx_reg, o_sy_reg;
    logic [QUOT_BITS:0]   magx, magy;
    logic [SRC_W-1:0]     sxm, sym, sx_next, sy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            v_reg[0]    <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            v_reg[0]    <= a_valid_reg;
            o_valid_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_nx_reg   <= MAG_W'(xv[VAL_W-1] ? -xv : xv);
            a_ny_reg   <= MAG_W'(yv[VAL_W-1] ? -yv : yv);
            a_d_reg    <= MAG_W'(wv[VAL_W-1] ? -wv : wv);
            a_negx_reg <= xv[VAL_W-1] ^ wv[VAL_W-1];
            a_negy_reg <= yv[VAL_W-1] ^ wv[VAL_W-1];
            a_wok_reg  <= (wv > W_POS) || (wv < W_NEG);

            wok_reg[0]  <= a_wok_reg;
            negx_reg[0] <= a_negx_reg;
            negy_reg[0] <= a_negy_reg;
            satx_reg[0] <= REM_W'(a_nx_reg) >= {a_d_reg, {QUOT_INT_BITS{1'b0}}};
            saty_reg[0] <= REM_W'(a_ny_reg) >= {a_d_reg, {QUOT_INT_BITS{1'b0}}};
            d_reg[0]    <= a_d_reg;
            rx_reg[0]   <= REM_W'(a_nx_reg);
            ry_reg[0]   <= REM_W'(a_ny_reg);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        logic [REM_W-1:0] dv, rxs, rys;
        logic [REM_W:0]   tx, ty;

        if (s < QUOT_INT_BITS)
        begin : g_int
            assign dv  = REM_W'(d_reg[s]) << (QUOT_INT_BITS - 1 - s);
            assign rxs = rx_reg[s];
            assign rys = ry_reg[s];
        end
        else
        begin : g_frac
            assign dv  = REM_W'(d_reg[s]);
            assign rxs = rx_reg[s] << 1;
            assign rys = ry_reg[s] << 1;
        end

        assign tx = {1'b0, rxs} - {1'b0, dv};
        assign ty = {1'b0, rys} - {1'b0, dv};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                wok_reg[s+1]  <= wok_reg[s];
                negx_reg[s+1] <= negx_reg[s];
                negy_reg[s+1] <= negy_reg[s];
                satx_reg[s+1] <= satx_reg[s];
                saty_reg[s+1] <= saty_reg[s];
                d_reg[s+1]    <= d_reg[s];
                rx_reg[s+1]   <= tx[REM_W] ? rxs : tx[REM_W-1:0];
                ry_reg[s+1]   <= ty[REM_W] ? rys : ty[REM_W-1:0];
                qx_reg[s+1]   <= {qx_reg[s][QUOT_BITS-2:0], ~tx[REM_W]};
                qy_reg[s+1]   <= {qy_reg[s][QUOT_BITS-2:0], ~ty[REM_W]};
            end
        end
    end

    // A negative quotient with a remainder is floored one step further down.
    always_comb
    begin
        magx = satx_reg[NS] ? {1'b1, {QUOT_BITS{1'b0}}}
             : (QUOT_BITS+1)'(qx_reg[NS])
               + (QUOT_BITS+1)'(negx_reg[NS] && (rx_reg[NS] != '0));
        magy = saty_reg[NS] ? {1'b1, {QUOT_BITS{1'b0}}}
             : (QUOT_BITS+1)'(qy_reg[NS])
               + (QUOT_BITS+1)'(negy_reg[NS] && (ry_reg[NS] != '0));
        sxm = SRC_W'(magx);
        sym = SRC_W'(magy);
        sx_next = negx_reg[NS] ? -sxm : sxm;
        sy_next = negy_reg[NS] ? -sym : sym;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_wok_reg <= wok_reg[NS];
            o_sx_reg  <= sx_next;
            o_sy_reg  <= sy_next;
        end
    end

    assign res = '{valid: o_valid_reg, w_ok: o_wok_reg, sx: o_sx_reg, sy: o_sy_reg};

endmodule

FILE: rtl/pbm_back.sv
module pbm_back
    import pbm_pkg::*;
#(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int MAX_SRC_DIM = DEF_MAX_SRC_DIM
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  proj_t       prj,
    input  cfg_t        cfg,
    output logic        out_valid,
    output logic [24:0] base_offset,
    output logic [1:0]  step_right,
    output logic [13:0] step_down,
    output logic [8:0]  weight_top_left,
    output logic [8:0]  weight_top_right,
    output logic [8:0]  weight_bottom_left,
    output logic [8:0]  weight_bottom_right
);

    localparam int DIMX_W = DIM_W + 1;
    localparam int PRW    = 34 + WEIGHT_BITS + 1;
    localparam int WQ_W   = PRW - 32;
    localparam logic [DIMX_W-1:0] SRC_MAX = DIMX_W'(MAX_SRC_DIM);
    localparam logic [WQ_W-1:0]   CAP     = WQ_W'(1) << WEIGHT_BITS;
    localparam logic [16:0]       ONE     = 17'(1) << FRAC_BITS;

    function automatic logic [8:0] round_weight(input logic [33:0] p);
        logic [PRW-1:0]  full;
        logic [WQ_W-1:0] wq;
        full = (PRW'(p) << WEIGHT_BITS) + (PRW'(1) << 31);
        wq = full[PRW-1:32];
        return 9'((wq > CAP) ? CAP : wq);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_tap(input logic signed [IX_W-1:0] v,
                                                  input logic signed [IX_W-1:0] hi);
        logic signed [IX_W-1:0] c;
        c = (v > hi) ? hi : v;
        c = (c < 0) ? '0 : c;
        return DIM_W'(c);
    endfunction

    logic [DIMX_W-1:0]      sw_c, sh_c;
    logic signed [IX_W-1:0] sws, shs, ix, iy, ix1, iy1;
    logic                   okx0, okx1, oky0, oky1;

    logic              s1_valid_reg, s2_valid_reg, o_valid_reg;
    logic [16:0]       ax_reg, ay_reg, omax_reg, omay_reg;
    logic [3:0]        tap_ok_reg, tap_ok2_reg;
    logic [DIM_W-1:0]  bx_reg, by_reg, bx2_reg;
    logic              sr_ok_reg, sd_ok_reg, sr_ok2_reg, sd_ok2_reg;
    logic [33:0]       p_reg [4];
    logic [2*DIM_W-1:0] bystr_reg;
    logic [2*DIM_W:0]  row_sum;
    logic [2*DIM_W+2:0] off_full;
    logic [DIM_W+1:0]  stride_bytes;

    logic [24:0] base_offset_reg;
    logic [1:0]  step_right_reg;
    logic [13:0] step_down_reg;
    logic [8:0]  wt_reg [4];

    always_comb
    begin
        sw_c = (DIMX_W'(cfg.src_w) > SRC_MAX) ? SRC_MAX : DIMX_W'(cfg.src_w);
        sh_c = (DIMX_W'(cfg.src_h) > SRC_MAX) ? SRC_MAX : DIMX_W'(cfg.src_h);
        sws = $signed(IX_W'(sw_c));
        shs = $signed(IX_W'(sh_c));
        ix = prj.w_ok ? $signed(prj.sx[SRC_W-1:FRAC_BITS]) : -IX_W'(2);
        iy = prj.w_ok ? $signed(prj.sy[SRC_W-1:FRAC_BITS]) : -IX_W'(2);
        ix1 = ix + IX_W'(1);
        iy1 = iy + IX_W'(1);
        okx0 = (ix >= 0) && (ix < sws);
        okx1 = (ix1 >= 0) && (ix1 < sws);
        oky0 = (iy >= 0) && (iy < shs);
        oky1 = (iy1 >= 0) && (iy1 < shs);
    end

    assign row_sum      = (2*DIM_W+1)'(bystr_reg) + (2*DIM_W+1)'(bx2_reg);
    assign off_full     = (2*DIM_W+3)'(row_sum) * (2*DIM_W+3)'(cfg.bpp);
    assign stride_bytes = (DIM_W+2)'(cfg.stride) * (DIM_W+2)'(cfg.bpp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= prj.valid;
            s2_valid_reg <= s1_valid_reg;
            o_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg     <= {1'b0, prj.sx[FRAC_BITS-1:0]};
            ay_reg     <= {1'b0, prj.sy[FRAC_BITS-1:0]};
            omax_reg   <= ONE - {1'b0, prj.sx[FRAC_BITS-1:0]};
            omay_reg   <= ONE - {1'b0, prj.sy[FRAC_BITS-1:0]};
            tap_ok_reg <= {okx1 && oky1, okx0 && oky1, okx1 && oky0, okx0 && oky0}
                          & {4{prj.w_ok}};
            bx_reg     <= clamp_tap(ix, sws - IX_W'(1));
            by_reg     <= clamp_tap(iy, shs - IX_W'(1));
            sr_ok_reg  <= (ix >= 0) && (ix1 < sws);
            sd_ok_reg  <= (iy >= 0) && (iy1 < shs);

            p_reg[0]    <= 34'(omax_reg) * 34'(omay_reg);
            p_reg[1]    <= 34'(ax_reg) * 34'(omay_reg);
            p_reg[2]    <= 34'(omax_reg) * 34'(ay_reg);
            p_reg[3]    <= 34'(ax_reg) * 34'(ay_reg);
            bystr_reg   <= (2*DIM_W)'(by_reg) * (2*DIM_W)'(cfg.stride);
            bx2_reg     <= bx_reg;
            tap_ok2_reg <= tap_ok_reg;
            sr_ok2_reg  <= sr_ok_reg;
            sd_ok2_reg  <= sd_ok_reg;

            base_offset_reg <= off_full[24:0];
            step_right_reg  <= sr_ok2_reg ? cfg.bpp : 2'd0;
            step_down_reg   <= sd_ok2_reg ? stride_bytes[13:0] : 14'd0;
            for (int i = 0; i < 4; i++)
            begin
                wt_reg[i] <= tap_ok2_reg[i] ? round_weight(p_reg[i]) : 9'd0;
            end
        end
    end

    assign out_valid           = o_valid_reg;
    assign base_offset         = base_offset_reg;
    assign step_right          = step_right_reg;
    assign step_down           = step_down_reg;
    assign weight_top_left     = wt_reg[0];
    assign weight_top_right    = wt_reg[1];
    assign weight_bottom_left  = wt_reg[2];
    assign weight_bottom_right = wt_reg[3];

endmodule
